// File: rtl/core/jass_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jass_pkg;

	localparam int SAMPLE_W  = 10;
	localparam int POS_W     = 16;
	localparam int CFG_IDX_W = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAN_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_STEP = 3'd4;

	localparam logic [SAMPLE_W-1:0] CENTRE_RST    = 10'd512;
	localparam logic [SAMPLE_W-1:0] RADIUS_RST    = 10'd30;
	localparam logic [SAMPLE_W-1:0] PAN_STEP_RST  = 10'd10;
	localparam logic [SAMPLE_W-1:0] TILT_STEP_RST = 10'd5;

	// average must sit more than this far off centre to move an axis
	localparam logic [SAMPLE_W-1:0] NEAR_BAND = 10'd15;

	localparam logic [POS_W-1:0] PAN_HOME  = 16'd375;
	localparam logic [POS_W-1:0] TILT_HOME = 16'd490;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [POS_W-1:0]    pos_t;

	typedef struct packed {
		sample_t centre_x;
		sample_t centre_y;
		sample_t radius;
		sample_t pan_step;
		sample_t tilt_step;
	} cfg_t;

	typedef struct packed {
		sample_t x;
		sample_t y;
	} pair_t;

	// per-stage load strobes from the pipeline control
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
		logic load_out;
	} pipe_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/jass_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface jass_in_if
	import jass_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t sample_x;
	sample_t sample_y;

	modport source (output valid, output sample_x, output sample_y, input ready);
	modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

interface jass_out_if
	import jass_pkg::*;
();
	logic    valid;
	logic    ready;
	pos_t    pan_position;
	pos_t    tilt_position;
	logic    outside_dead;
	logic    pan_moved;
	logic    tilt_moved;
	sample_t mean_x;
	sample_t mean_y;

	modport source (output valid, output pan_position, output tilt_position,
		output outside_dead, output pan_moved, output tilt_moved,
		output mean_x, output mean_y, input ready);
	modport sink   (input valid, input pan_position, input tilt_position,
		input outside_dead, input pan_moved, input tilt_moved,
		input mean_x, input mean_y, output ready);
endinterface

`default_nettype wire

// File: rtl/core/joystick_averaged_servo_stepper.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Kind            Payload
// joy       in   valid/ready     sample_x, sample_y (10 b each)
// servo     out  valid/ready     pan/tilt_position (16 b), outside_dead, pan_moved,
//                                tilt_moved, mean_x, mean_y (10 b each)
// cfg_*     in   write only      cfg_index (3 b), cfg_wr_data (10 b)
//
// One transaction per clock sustained while servo.ready stays high; a result passes
// through the input register, deadband test, ring/sum update and position step.
// The running-sum and position loops each close through a single register.
// Reset clears sums, slot, fill flag and positions at once; the ring memory is
// not swept, a fill flag masks entries not yet written.
// Stalls on servo let the stages upstream keep filling empty slots before
// joy.ready drops.
module joystick_averaged_servo_stepper
	import jass_pkg::*;
#(
	parameter int          AVG_DEPTH = 8,
	parameter int unsigned PAN_MIN   = 100,
	parameter int unsigned PAN_MAX   = 650,
	parameter int unsigned TILT_MIN  = 100,
	parameter int unsigned TILT_MAX  = 650
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	jass_in_if.sink                   joy,
	jass_out_if.source                servo,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire sample_t              cfg_wr_data
);

	cfg_t      cfg_q;
	pipe_ctl_t ctl;

	// stage occupancy
	logic v1_q;
	logic v2_q;
	logic v3_q;
	logic vo_q;

	logic adv1;
	logic adv2;
	logic adv3;
	logic out_take;

	pair_t   pair_s2;
	logic    outside_s2;
	logic    outside_s3;
	sample_t avg_x;
	sample_t avg_y;

	// configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre_x  <= CENTRE_RST;
			cfg_q.centre_y  <= CENTRE_RST;
			cfg_q.radius    <= RADIUS_RST;
			cfg_q.pan_step  <= PAN_STEP_RST;
			cfg_q.tilt_step <= TILT_STEP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CENTRE_X:  cfg_q.centre_x  <= cfg_wr_data;
				CFG_CENTRE_Y:  cfg_q.centre_y  <= cfg_wr_data;
				CFG_RADIUS:    cfg_q.radius    <= cfg_wr_data;
				CFG_PAN_STEP:  cfg_q.pan_step  <= cfg_wr_data;
				CFG_TILT_STEP: cfg_q.tilt_step <= cfg_wr_data;
				default: begin
				end
			endcase
		end
	end

	// each stage moves when the one after it is empty or moving
	assign out_take  = v3_q && (!vo_q || servo.ready);
	assign adv3      = !v3_q || out_take;
	assign adv2      = !v2_q || adv3;
	assign adv1      = !v1_q || adv2;
	assign joy.ready = adv1;

	assign ctl.load_s1  = joy.valid && adv1;
	assign ctl.load_s2  = v1_q && adv2;
	assign ctl.load_s3  = v2_q && adv3;
	assign ctl.load_out = out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (adv1) begin
				v1_q <= joy.valid;
			end
			if (adv2) begin
				v2_q <= v1_q;
			end
			if (adv3) begin
				v3_q <= v2_q;
			end
			if (out_take) begin
				vo_q <= 1'b1;
			end else if (servo.ready) begin
				vo_q <= 1'b0;
			end
		end
	end

	jass_deadband u_deadband (
		.clk        (clk),
		.ctl        (ctl),
		.cfg        (cfg_q),
		.sample_x   (joy.sample_x),
		.sample_y   (joy.sample_y),
		.pair_s2    (pair_s2),
		.outside_s2 (outside_s2)
	);

	jass_ring #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.pair_s2    (pair_s2),
		.outside_s2 (outside_s2),
		.outside_s3 (outside_s3),
		.avg_x      (avg_x),
		.avg_y      (avg_y)
	);

	// position state doubles as the result register
	jass_stepper #(
		.PAN_MIN  (PAN_MIN),
		.PAN_MAX  (PAN_MAX),
		.TILT_MIN (TILT_MIN),
		.TILT_MAX (TILT_MAX)
	) u_stepper (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cfg          (cfg_q),
		.outside_s3   (outside_s3),
		.avg_x        (avg_x),
		.avg_y        (avg_y),
		.pan_q        (servo.pan_position),
		.tilt_q       (servo.tilt_position),
		.avg_x_q      (servo.mean_x),
		.avg_y_q      (servo.mean_y),
		.outside_q    (servo.outside_dead),
		.pan_moved_q  (servo.pan_moved),
		.tilt_moved_q (servo.tilt_moved)
	);

	assign servo.valid = vo_q;

endmodule

`default_nettype wire

// File: rtl/core/jass_deadband.sv
`timescale 1ns / 1ps
`default_nettype none

// Input register and radial deadband test.
module jass_deadband
	import jass_pkg::*;
(
	input  wire logic      clk,
	input  wire pipe_ctl_t ctl,
	input  wire cfg_t      cfg,
	input  wire sample_t   sample_x,
	input  wire sample_t   sample_y,
	output pair_t          pair_s2,
	output logic           outside_s2
);

	pair_t              pair_s1;
	logic signed [10:0] dx;
	logic signed [10:0] dy;
	logic        [19:0] sq_x;
	logic        [19:0] sq_y;
	logic        [19:0] r_sq;
	logic        [20:0] dist_sq;
	logic               outside;

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			pair_s1.x <= sample_x;
			pair_s1.y <= sample_y;
		end
	end

	always_comb begin
		dx      = $signed({1'b0, pair_s1.x}) - $signed({1'b0, cfg.centre_x});
		dy      = $signed({1'b0, pair_s1.y}) - $signed({1'b0, cfg.centre_y});
		sq_x    = 20'(dx * dx);
		sq_y    = 20'(dy * dy);
		r_sq    = 20'(cfg.radius * cfg.radius);
		dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
		outside = dist_sq > {1'b0, r_sq};
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			pair_s2    <= pair_s1;
			outside_s2 <= outside;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/jass_ring.sv
`timescale 1ns / 1ps
`default_nettype none

// Ring buffer of sample pairs with running sums and the divide by depth.
// The entry at the write slot is prefetched into rd_q so that the
// oldest sample is ready without a read cycle.
module jass_ring
	import jass_pkg::*;
#(
	parameter int AVG_DEPTH = 8
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire pipe_ctl_t ctl,
	input  wire pair_t     pair_s2,
	input  wire logic      outside_s2,
	output logic           outside_s3,
	output sample_t        avg_x,
	output sample_t        avg_y
);

	localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int SUM_W  = SAMPLE_W + $clog2(AVG_DEPTH);
	localparam int DIV_SH = SUM_W + $clog2(AVG_DEPTH);
	localparam int RCP_W  = SUM_W + 1;
	localparam int PROD_W = SUM_W + RCP_W;
	// ceil(2^DIV_SH / depth): exact quotient for every sum below 2^SUM_W
	localparam longint RECIP_L =
		((longint'(1) << DIV_SH) + longint'(AVG_DEPTH) - 1) / longint'(AVG_DEPTH);
	localparam logic [RCP_W-1:0]  RECIP     = RCP_W'(RECIP_L);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(AVG_DEPTH - 1);

	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_nx;
	logic              last;
	logic              full_q;
	logic              rd_ok_q;
	pair_t             rd_q;
	pair_t             oldest;
	logic [SUM_W-1:0]  sum_x_q;
	logic [SUM_W-1:0]  sum_y_q;
	logic [SUM_W-1:0]  sum_x_d;
	logic [SUM_W-1:0]  sum_y_d;
	logic [PROD_W-1:0] prod_x;
	logic [PROD_W-1:0] prod_y;
	logic              update;

	assign update  = ctl.load_s3 && outside_s2;
	assign last    = (slot_q == LAST_SLOT);
	assign slot_nx = last ? '0 : slot_q + 1'b1;
	// entries never written since reset read as zero
	assign oldest  = rd_ok_q ? rd_q : '0;
	assign sum_x_d = sum_x_q - SUM_W'(oldest.x) + SUM_W'(pair_s2.x);
	assign sum_y_d = sum_y_q - SUM_W'(oldest.y) + SUM_W'(pair_s2.y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			full_q     <= 1'b0;
			rd_ok_q    <= 1'b0;
			sum_x_q    <= '0;
			sum_y_q    <= '0;
			outside_s3 <= 1'b0;
		end else begin
			if (ctl.load_s3) begin
				outside_s3 <= outside_s2;
			end
			if (update) begin
				sum_x_q <= sum_x_d;
				sum_y_q <= sum_y_d;
				slot_q  <= slot_nx;
				full_q  <= full_q | last;
				rd_ok_q <= full_q | last;
			end
		end
	end

	generate
		if (AVG_DEPTH == 1) begin : g_single
			always_ff @(posedge clk) begin
				if (update) begin
					rd_q <= pair_s2;
				end
			end
		end else begin : g_mem
			pair_t mem [AVG_DEPTH];

			always_ff @(posedge clk) begin
				if (update) begin
					mem[slot_q] <= pair_s2;
					rd_q        <= mem[slot_nx];
				end
			end
		end
	endgenerate

	assign prod_x = PROD_W'(sum_x_q) * PROD_W'(RECIP);
	assign prod_y = PROD_W'(sum_y_q) * PROD_W'(RECIP);
	assign avg_x  = prod_x[DIV_SH +: SAMPLE_W];
	assign avg_y  = prod_y[DIV_SH +: SAMPLE_W];

endmodule

`default_nettype wire

// File: rtl/core/jass_stepper.sv
`timescale 1ns / 1ps
`default_nettype none

// Pan/tilt position state; its registers are also the result register.
module jass_stepper
	import jass_pkg::*;
#(
	parameter int unsigned PAN_MIN  = 100,
	parameter int unsigned PAN_MAX  = 650,
	parameter int unsigned TILT_MIN = 100,
	parameter int unsigned TILT_MAX = 650
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire pipe_ctl_t ctl,
	input  wire cfg_t      cfg,
	input  wire logic      outside_s3,
	input  wire sample_t   avg_x,
	input  wire sample_t   avg_y,
	output pos_t           pan_q,
	output pos_t           tilt_q,
	output sample_t        avg_x_q,
	output sample_t        avg_y_q,
	output logic           outside_q,
	output logic           pan_moved_q,
	output logic           tilt_moved_q
);

	localparam pos_t PAN_LO  = POS_W'(PAN_MIN);
	localparam pos_t PAN_HI  = POS_W'(PAN_MAX);
	localparam pos_t TILT_LO = POS_W'(TILT_MIN);
	localparam pos_t TILT_HI = POS_W'(TILT_MAX);

	// one step toward the side of the average, kept strictly inside (lo, hi)
	function automatic pos_t step_axis(pos_t pos, sample_t avg, sample_t centre,
		sample_t step, pos_t lo, pos_t hi);
		logic          below;
		logic          above;
		logic          dn_ok;
		logic          up_ok;
		logic [POS_W:0] step_w;
		pos_t           res;
		step_w = (POS_W + 1)'(step);
		below  = ({1'b0, avg} + {1'b0, NEAR_BAND}) < {1'b0, centre};
		above  = {1'b0, avg} > ({1'b0, centre} + {1'b0, NEAR_BAND});
		dn_ok  = {1'b0, pos} > ({1'b0, lo} + step_w);
		up_ok  = ({1'b0, pos} + step_w) < {1'b0, hi};
		res    = pos;
		if (below) begin
			if (dn_ok) begin
				res = pos - POS_W'(step);
			end
		end else if (above) begin
			if (up_ok) begin
				res = pos + POS_W'(step);
			end
		end
		return res;
	endfunction

	pos_t pan_nx;
	pos_t tilt_nx;

	assign pan_nx  = step_axis(pan_q, avg_x, cfg.centre_x, cfg.pan_step, PAN_LO, PAN_HI);
	assign tilt_nx = step_axis(tilt_q, avg_y, cfg.centre_y, cfg.tilt_step, TILT_LO, TILT_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_q        <= PAN_HOME;
			tilt_q       <= TILT_HOME;
			avg_x_q      <= '0;
			avg_y_q      <= '0;
			outside_q    <= 1'b0;
			pan_moved_q  <= 1'b0;
			tilt_moved_q <= 1'b0;
		end else if (ctl.load_out) begin
			outside_q    <= outside_s3;
			pan_moved_q  <= outside_s3 && (pan_nx != pan_q);
			tilt_moved_q <= outside_s3 && (tilt_nx != tilt_q);
			if (outside_s3) begin
				avg_x_q <= avg_x;
				avg_y_q <= avg_y;
				pan_q   <= pan_nx;
				tilt_q  <= tilt_nx;
			end
		end
	end

endmodule

`default_nettype wire

// File: tb/jass_servo_checker.sv
`timescale 1ns / 1ps

// Watches the joy, servo and config ports, models the averaging stepper and
// compares each servo transaction with the oldest predicted one.
module jass_servo_checker
	import jass_pkg::*;
#(
	parameter int AVG_DEPTH = 8,
	parameter int PAN_MIN   = 100,
	parameter int PAN_MAX   = 650,
	parameter int TILT_MIN  = 100,
	parameter int TILT_MAX  = 650
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	jass_in_if                        joy,
	jass_out_if                       servo,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire sample_t              cfg_wr_data,
	output int                        errors,
	output int                        pending,
	output int                        n_checked,
	output int                        n_outside,
	output int                        n_pan_steps,
	output int                        n_tilt_steps
);

	typedef struct {
		pos_t    pan;
		pos_t    tilt;
		logic    outside;
		logic    pan_mv;
		logic    tilt_mv;
		sample_t mx;
		sample_t my;
	} servo_word_t;

	// register copy
	sample_t ctr_x, ctr_y, dead_r, pan_inc, tilt_inc;

	// model state
	sample_t        ring_x [AVG_DEPTH];
	sample_t        ring_y [AVG_DEPTH];
	logic [12:0]    sum_x, sum_y;
	int             slot;
	sample_t        mean_x, mean_y;
	pos_t           pan_pos, tilt_pos;

	servo_word_t servo_due[$];
	servo_word_t head;

	task automatic flag_mismatch(input string field, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, expected %0d (result %0d)",
			$time, field, got, want, n_checked);
		errors++;
	endtask

	function automatic pos_t nudge(pos_t pos, sample_t mean, sample_t ctr, sample_t inc,
		int lo, int hi);
		int p, a, c, s, band;
		p    = pos;
		a    = mean;
		c    = ctr;
		s    = inc;
		band = NEAR_BAND;
		if (a < c - band) begin
			if (p - s > lo)
				p -= s;
		end else if (a > c + band) begin
			if (p + s < hi)
				p += s;
		end
		return pos_t'(p);
	endfunction

	function automatic servo_word_t step_joystick(sample_t sx, sample_t sy);
		servo_word_t w;
		int dx, dy, r;
		dx = int'(sx) - int'(ctr_x);
		dy = int'(sy) - int'(ctr_y);
		r  = dead_r;
		w.outside = (dx * dx + dy * dy) > (r * r);
		w.pan_mv  = 1'b0;
		w.tilt_mv = 1'b0;
		if (w.outside) begin
			sum_x = sum_x - ring_x[slot] + sx;
			sum_y = sum_y - ring_y[slot] + sy;
			ring_x[slot] = sx;
			ring_y[slot] = sy;
			slot = (slot + 1 >= AVG_DEPTH) ? 0 : slot + 1;
			mean_x = sum_x / AVG_DEPTH;
			mean_y = sum_y / AVG_DEPTH;
			w.pan  = nudge(pan_pos, mean_x, ctr_x, pan_inc, PAN_MIN, PAN_MAX);
			w.tilt = nudge(tilt_pos, mean_y, ctr_y, tilt_inc, TILT_MIN, TILT_MAX);
			w.pan_mv  = w.pan != pan_pos;
			w.tilt_mv = w.tilt != tilt_pos;
			pan_pos  = w.pan;
			tilt_pos = w.tilt;
		end
		w.pan  = pan_pos;
		w.tilt = tilt_pos;
		w.mx   = mean_x;
		w.my   = mean_y;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_x    = CENTRE_RST;
			ctr_y    = CENTRE_RST;
			dead_r   = RADIUS_RST;
			pan_inc  = PAN_STEP_RST;
			tilt_inc = TILT_STEP_RST;
			foreach (ring_x[i]) begin
				ring_x[i] = '0;
				ring_y[i] = '0;
			end
			sum_x    = '0;
			sum_y    = '0;
			slot     = 0;
			mean_x   = '0;
			mean_y   = '0;
			pan_pos  = PAN_HOME;
			tilt_pos = TILT_HOME;
			servo_due.delete();
			errors       = 0;
			pending      = 0;
			n_checked    = 0;
			n_outside    = 0;
			n_pan_steps  = 0;
			n_tilt_steps = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_CENTRE_X:  ctr_x    = cfg_wr_data;
					CFG_CENTRE_Y:  ctr_y    = cfg_wr_data;
					CFG_RADIUS:    dead_r   = cfg_wr_data;
					CFG_PAN_STEP:  pan_inc  = cfg_wr_data;
					CFG_TILT_STEP: tilt_inc = cfg_wr_data;
					default: ;
				endcase
			end
			if (joy.valid && joy.ready)
				servo_due.push_back(step_joystick(joy.sample_x, joy.sample_y));
			if (servo.valid && servo.ready) begin
				if (servo_due.size() == 0) begin
					flag_mismatch("unexpected result", 1, 0);
				end else begin
					head = servo_due.pop_front();
					if (servo.pan_position !== head.pan)
						flag_mismatch("pan_position", servo.pan_position, head.pan);
					if (servo.tilt_position !== head.tilt)
						flag_mismatch("tilt_position", servo.tilt_position, head.tilt);
					if (servo.outside_dead !== head.outside)
						flag_mismatch("outside_dead", servo.outside_dead, head.outside);
					if (servo.pan_moved !== head.pan_mv)
						flag_mismatch("pan_moved", servo.pan_moved, head.pan_mv);
					if (servo.tilt_moved !== head.tilt_mv)
						flag_mismatch("tilt_moved", servo.tilt_moved, head.tilt_mv);
					if (servo.mean_x !== head.mx)
						flag_mismatch("mean_x", servo.mean_x, head.mx);
					if (servo.mean_y !== head.my)
						flag_mismatch("mean_y", servo.mean_y, head.my);
					n_outside    += head.outside;
					n_pan_steps  += head.pan_mv;
					n_tilt_steps += head.tilt_mv;
				end
				n_checked++;
			end
			pending = servo_due.size();
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the joystick averaging stepper. All prediction and
// comparison live in jass_servo_checker; this module only drives the ports.
module tb_top;
	import jass_pkg::*;

	localparam int N_PHASES    = 14;   // random register settings after the directed part
	localparam int PHASE_ITEMS = 30;   // joystick transactions per random phase
	localparam int HOLD_CYCLES = 60;   // one long servo-side back-pressure window
	localparam int CYCLE_LIMIT = 150000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	sample_t cfg_wr_data;

	jass_in_if  joy_if();
	jass_out_if servo_if();

	int errors, pending, n_checked, n_outside, n_pan_steps, n_tilt_steps;

	// idle_pct: chance (percent) that a side starts an idle burst before its next slot
	int   idle_pct = 0;
	logic hold_req = 1'b0;
	int   cycles;

	// current register values, used to aim the stimulus around the deadband
	int cur_cx, cur_cy, cur_r;

	always #5 clk = ~clk;

	joystick_averaged_servo_stepper i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.joy        (joy_if),
		.servo      (servo_if),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wr_data(cfg_wr_data)
	);

	jass_servo_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.joy         (joy_if),
		.servo       (servo_if),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.errors      (errors),
		.pending     (pending),
		.n_checked   (n_checked),
		.n_outside   (n_outside),
		.n_pan_steps (n_pan_steps),
		.n_tilt_steps(n_tilt_steps)
	);

	function automatic sample_t clip10(int v);
		if (v < 0)
			return '0;
		if (v > 1023)
			return '1;
		return sample_t'(v);
	endfunction

	// Aim point for a run of samples: hard low, hard high, near centre, or anywhere.
	function automatic int pick_aim(int c);
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 80);
			1:       return $urandom_range(940, 1023);
			2:       return c + int'($urandom_range(0, 120)) - 60;
			default: return $urandom_range(0, 1023);
		endcase
	endfunction

	// One joystick transaction. Entered and left on a falling edge; valid stays up
	// between back-to-back transactions so it is never dropped and raised in one step.
	task automatic send_pair(input int x, input int y);
		int gap;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 14);
			joy_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		joy_if.valid    <= 1'b1;
		joy_if.sample_x <= clip10(x);
		joy_if.sample_y <= clip10(y);
		do
			@(posedge clk);
		while (!joy_if.ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted result has come back, then let the
	// clock run on so that the pipe is surely empty.
	task automatic settle();
		joy_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write all five registers, one per cycle; only called with the block idle.
	task automatic load_settings(input int cx, input int cy, input int r, input int ps,
		input int ts);
		logic [CFG_IDX_W-1:0] idx [5];
		int vals [5];
		idx  = '{CFG_CENTRE_X, CFG_CENTRE_Y, CFG_RADIUS, CFG_PAN_STEP, CFG_TILT_STEP};
		vals = '{cx, cy, r, ps, ts};
		for (int i = 0; i < 5; i++) begin
			@(negedge clk);
			cfg_wr_en   <= 1'b1;
			cfg_index   <= idx[i];
			cfg_wr_data <= clip10(vals[i]);
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_cx = cx;
		cur_cy = cy;
		cur_r  = r;
	endtask

	// Servo-side ready: random stall bursts, plus one long hold when asked for.
	initial begin
		int stall_left, hold_left;
		bit hold_done;
		stall_left = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		servo_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				servo_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				servo_if.ready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(1, 14) - 1;
				servo_if.ready <= 1'b0;
			end else begin
				servo_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
				$display("[joystick_averaged_servo_stepper] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int ps, ts, sent, mode, len, ax, ay, off, d, pct;
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_index       = CFG_CENTRE_X;
		cfg_wr_data     = '0;
		joy_if.valid    = 1'b0;
		joy_if.sample_x = '0;
		joy_if.sample_y = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ---- directed part, reset-value registers written explicitly ----
		idle_pct <= 20;
		load_settings(CENTRE_RST, CENTRE_RST, RADIUS_RST, PAN_STEP_RST, TILT_STEP_RST);
		send_pair(512, 512);            // dead centre, ignored
		send_pair(542, 512);            // exactly on the radius: still inside
		send_pair(512, 481);            // one past the radius; ring still mostly zeros
		send_pair(543, 512);
		send_pair(0, 0);
		send_pair(1023, 1023);
		send_pair(1023, 0);
		send_pair(0, 1023);
		send_pair(10'h2AA, 10'h155);
		send_pair(10'h155, 10'h2AA);
		repeat (8) send_pair(1023, 1023); // fill the ring high, averages climb, steps up
		settle();

		// zero step size: direction test passes but nothing moves
		load_settings(512, 512, 30, 0, 0);
		send_pair(0, 0);
		send_pair(1023, 1023);
		send_pair(0, 1023);
		settle();

		// step so large that neither bound can be met
		load_settings(512, 512, 30, 1023, 1023);
		send_pair(0, 0);
		send_pair(1023, 1023);
		settle();

		// ---- random phases ----
		for (int ph = 0; ph < N_PHASES; ph++) begin
			ps = $urandom_range(1, 40);
			ts = $urandom_range(1, 40);
			case (ph)
				3:       load_settings(0, 0, 0, ps, ts);
				6:       load_settings(1023, 1023, 1023, ps, ts);
				9:       load_settings($urandom_range(200, 824), $urandom_range(200, 824), 0,
					1023, 0);
				12:      load_settings(1023, 0, $urandom_range(0, 60), 0, 1023);
				default: load_settings($urandom_range(200, 824), $urandom_range(200, 824),
					$urandom_range(0, 100), ps, ts);
			endcase

			case ($urandom_range(0, 3))
				0:       pct = 0;
				1:       pct = 10;
				2:       pct = 25;
				default: pct = 40;
			endcase
			// back-pressure window: the servo side holds off while joy keeps offering
			if (ph == 7) begin
				pct = 0;
				hold_req <= 1'b1;
			end
			// the tail of the run goes without idling on either side
			if (ph == N_PHASES - 1)
				pct = 0;
			idle_pct <= pct;
			@(negedge clk);

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				mode = $urandom_range(0, 9);
				if (mode <= 5) begin
					// steady deflection with jitter: walks positions into the limits
					len = $urandom_range(6, 24);
					ax  = pick_aim(cur_cx);
					ay  = pick_aim(cur_cy);
					for (int k = 0; k < len; k++)
						send_pair(ax + int'($urandom_range(0, 12)) - 6,
							ay + int'($urandom_range(0, 12)) - 6);
					sent += len;
				end else if (mode <= 7) begin
					len = $urandom_range(1, 4);
					repeat (len) send_pair($urandom_range(0, 1023), $urandom_range(0, 1023));
					sent += len;
				end else if (mode == 8) begin
					// inside the deadband: held outputs
					len = $urandom_range(1, 5);
					for (int k = 0; k < len; k++) begin
						off = int'($urandom_range(0, cur_r)) - cur_r / 2;
						send_pair(cur_cx + off, cur_cy - off);
					end
					sent += len;
				end else begin
					// on and just past the radius along each axis
					case ($urandom_range(0, 3))
						0:       d = cur_r;
						1:       d = cur_r + 1;
						2:       d = -cur_r;
						default: d = -cur_r - 1;
					endcase
					send_pair(cur_cx + d, cur_cy);
					send_pair(cur_cx, cur_cy + d);
					sent += 2;
				end
			end
			settle();
		end

		repeat (8) @(posedge clk);
		$display("%0d servo results checked, %0d beyond the deadband, %0d pan and %0d tilt steps",
			n_checked, n_outside, n_pan_steps, n_tilt_steps);
		$display("%0d register settings incl. extremes, one %0d-cycle servo hold-off",
			N_PHASES + 3, HOLD_CYCLES);
		if (errors == 0 && pending == 0)
			$display("[joystick_averaged_servo_stepper] OK");
		else
			$display("[joystick_averaged_servo_stepper] ERROR");
		$finish;
	end

endmodule
